[design/ifmt_pkg.sv]
// ----------------------------------------------------------------------------
// ifmt_pkg
// Types, codes and character helpers shared by the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int LEN_W     = 8;   // field lengths and counts, up to 64
  localparam int DIV_BITS  = 4;   // quotient bits resolved per divider cycle
  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 36;
  localparam int MAX_FIELD = 64;
  localparam int MAX_PREC  = 61;
  localparam int X_INDEX   = 33;  // digit set position of the hex prefix letter

  // format flag bit positions
  localparam int FL_ZERO   = 0;
  localparam int FL_SIGNED = 1;
  localparam int FL_PLUS   = 2;
  localparam int FL_SPACE  = 3;
  localparam int FL_LEFT   = 4;
  localparam int FL_PREFIX = 5;
  localparam int FL_LOWER  = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  base;
    logic [6:0]  width;
    logic [5:0]  precision;
    logic [6:0]  format_flags;
  } ifmt_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_last;
    logic       bad_base;
  } ifmt_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BAD,
    S_DIV,
    S_SETUP,
    S_SIZE,
    S_LOAD,
    S_LEAD,
    S_SIGN,
    S_PFX,
    S_ZPAD,
    S_PREC,
    S_DIG,
    S_TRAIL
  } ifmt_state_t;

  // controller to datapath
  typedef struct packed {
    logic        accept;    // capture item, load divider
    logic        div_step;  // one divider cycle
    logic        setup;     // precision and fixed length
    logic        size;      // padding and field length
    logic        ld_cnt;    // load phase counter for phase
    logic        emit;      // emit one character of phase
    ifmt_state_t phase;
  } ifmt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_bad;     // base on the input port out of range
    logic dig_done;   // divider on its last cycle of a digit
    logic q_zero;     // quotient after this cycle is zero
    logic cnt_zero;   // phase counter exhausted
    logic len_done;   // whole (or cut) field emitted
  } ifmt_sts_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
    logic [5:0] m;
    logic [7:0] c;
    m = (d >= 6'(RADIX_MAX)) ? d - 6'(RADIX_MAX) : d;
    if (m < 6'd10) begin
      c = CH_ZERO + {2'b00, m};
    end else begin
      c = (lower ? CH_LOWER : CH_UPPER) + {2'b00, m} - 8'd10;
    end
    return c;
  endfunction

endpackage

[design/integer_field_formatter.sv]
// ----------------------------------------------------------------------------
// integer_field_formatter
// printf-style text of one integer, one character per result.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the item is taken at the edge where
// start is high and busy is low. busy stays high until the item's last
// character has left the sequencer. Characters appear on out_data for one
// cycle each, marked by out_valid, in field order, with is_last on the final
// one; there is no back-pressure, the receiver must take every transfer.
// A base outside 2..36 gives a single transfer with bad_base and is_last set
// and out_char zero, sent from the S_BAD state through the character pipeline.
// Sequence: the divider resolves 4 quotient bits a cycle, digit by digit until
// the quotient is zero. After the last digit come the setup steps S_SETUP,
// S_SIZE and S_LOAD, then the 7 emit phases in order, one character a cycle
// within a phase with a counter load between phases; each character passes the
// stage 1 and output registers after its emit slot.
// Reset clears the sequencer and the output strobe; nothing else needs it.
// ----------------------------------------------------------------------------
module integer_field_formatter import ifmt_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ifmt_in_t  in_data,
  output logic      out_valid,
  output ifmt_out_t out_data
);

  ifmt_cmd_t cmd;
  ifmt_sts_t sts;

  ifmt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ifmt_dpath #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // invalid radix answers with a flagged, final transfer
  a_bad_base_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy &&
     (in_data.base < 6'(RADIX_MIN) || in_data.base > 6'(RADIX_MAX)))
    |-> ##3 (out_valid && out_data.bad_base && out_data.is_last))
    else $error("bad base not reported");

  a_bad_base_text: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_base) |-> (out_data.is_last && out_data.out_char == CH_NUL))
    else $error("bad base transfer carries text");

  // the closing character of a field leaves as the sequencer goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_last && !out_data.bad_base) |-> !busy)
    else $error("last character while still sequencing");

endmodule

[design/ifmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Sequencer: digit extraction, length setup, emit phases in order, or one bad-base reply.
// ----------------------------------------------------------------------------
module ifmt_ctrl import ifmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ifmt_sts_t   sts,
  output ifmt_cmd_t   cmd
);

  ifmt_state_t state_r, state_nxt;

  function automatic ifmt_state_t next_phase(input ifmt_state_t s);
    ifmt_state_t n;
    case (s)
      S_LEAD:  n = S_SIGN;
      S_SIGN:  n = S_PFX;
      S_PFX:   n = S_ZPAD;
      S_ZPAD:  n = S_PREC;
      S_PREC:  n = S_DIG;
      S_DIG:   n = S_TRAIL;
      default: n = S_IDLE;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.phase = S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_bad ? S_BAD : S_DIV;
        end
      end
      S_BAD: begin
        cmd.emit  = 1'b1;
        cmd.phase = S_BAD;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.dig_done && sts.q_zero) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SIZE;
      end
      S_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.ld_cnt = 1'b1;
        cmd.phase  = S_LEAD;
        state_nxt  = S_LEAD;
      end
      S_LEAD, S_SIGN, S_PFX, S_ZPAD, S_PREC, S_DIG, S_TRAIL: begin
        if (sts.len_done) begin
          state_nxt = S_IDLE;
        end else if (sts.cnt_zero) begin
          state_nxt = next_phase(state_r);
          if (state_r != S_TRAIL) begin
            cmd.ld_cnt = 1'b1;
            cmd.phase  = next_phase(state_r);
          end
        end else begin
          cmd.emit  = 1'b1;
          cmd.phase = state_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[design/ifmt_dpath.sv]
// ----------------------------------------------------------------------------
// ifmt_dpath
// Radix divider, digit store, length arithmetic and the character pipeline.
// ----------------------------------------------------------------------------
module ifmt_dpath import ifmt_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ifmt_in_t   in_data,
  input  ifmt_cmd_t  cmd,
  output ifmt_sts_t  sts,
  output logic       out_valid,
  output ifmt_out_t  out_data
);

  localparam int QW  = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int SPD = QW / DIV_BITS;
  localparam int SCW = (SPD > 1) ? $clog2(SPD) : 1;
  localparam int AW  = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int CW  = $clog2(DIGIT_SLOTS + 1);

  // input decode
  logic [VALUE_BITS+31:0] val_ext;
  logic [VALUE_BITS-1:0]  val_v;
  logic [VALUE_BITS-1:0]  val_mag;
  logic                   val_neg;
  logic [6:0]             fl;

  assign val_ext = {{VALUE_BITS{1'b0}}, in_data.value};
  assign val_v   = val_ext[VALUE_BITS-1:0];
  assign fl      = in_data.format_flags;
  assign val_neg = fl[FL_SIGNED] & val_v[VALUE_BITS-1];
  // most negative value wraps onto itself, read unsigned afterwards
  assign val_mag = val_neg ? (VALUE_BITS'(0) - val_v) : val_v;

  // item registers
  logic [5:0]       base_r;
  logic             lower_r;
  logic             left_r;
  logic             zero_r;
  logic             sign_en_r;
  logic [7:0]       sign_ch_r;
  logic [1:0]       pfxlen_r;
  logic [6:0]       width_r;
  logic [5:0]       prec_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r    <= in_data.base;
      lower_r   <= fl[FL_LOWER];
      left_r    <= fl[FL_LEFT];
      zero_r    <= fl[FL_ZERO] & ~fl[FL_LEFT];
      sign_en_r <= val_neg | fl[FL_PLUS] | fl[FL_SPACE];
      sign_ch_r <= val_neg ? CH_MINUS : (fl[FL_PLUS] ? CH_PLUS : CH_SPACE);
      if (!fl[FL_PREFIX]) begin
        pfxlen_r <= 2'd0;
      end else if (in_data.base == 6'd16) begin
        pfxlen_r <= 2'd2;
      end else if (in_data.base == 6'd8) begin
        pfxlen_r <= 2'd1;
      end else begin
        pfxlen_r <= 2'd0;
      end
      width_r <= (in_data.width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : in_data.width;
      prec_r  <= (in_data.precision > 6'(MAX_PREC)) ? 6'(MAX_PREC) : in_data.precision;
    end
  end

  // restoring radix divider, DIV_BITS quotient bits per cycle
  logic [QW-1:0]  q_r, q_nxt;
  logic [6:0]     rem_r, rem_nxt;
  logic [SCW-1:0] step_r;
  logic [CW-1:0]  dc_r;
  logic           step_last;

  always_comb begin
    logic [6:0]    r;
    logic [QW-1:0] q;
    logic          ge;
    r = rem_r;
    q = q_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r  = {r[5:0], q[QW-1]};
      ge = (r >= {1'b0, base_r});
      if (ge) r = r - {1'b0, base_r};
      q  = {q[QW-2:0], ge};
    end
    rem_nxt = r;
    q_nxt   = q;
  end

  assign step_last = (step_r == SCW'(SPD - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_r    <= QW'(val_mag);
      rem_r  <= '0;
      step_r <= '0;
      dc_r   <= '0;
    end else if (cmd.div_step) begin
      q_r <= q_nxt;
      if (step_last) begin
        rem_r  <= '0;
        step_r <= '0;
        if (dc_r < CW'(DIGIT_SLOTS)) dc_r <= dc_r + CW'(1);
      end else begin
        rem_r  <= rem_nxt;
        step_r <= step_r + SCW'(1);
      end
    end
  end

  // digit store, least significant digit first; overflow digits are dropped
  logic [5:0]    dstore [DIGIT_SLOTS];
  logic [5:0]    rd_data_r;
  logic [LEN_W-1:0] cnt_r;
  logic [LEN_W-1:0] cnt_m1;
  logic [AW-1:0] rd_addr;

  assign cnt_m1  = cnt_r - LEN_W'(1);
  assign rd_addr = cnt_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_step && step_last && (dc_r < CW'(DIGIT_SLOTS))) begin
      dstore[dc_r[AW-1:0]] <= rem_nxt[5:0];
    end
    if (cmd.emit && (cmd.phase == S_DIG)) begin
      rd_data_r <= dstore[rd_addr];
    end
  end

  // lengths
  logic [LEN_W-1:0] dc_ext, prec_ext, prec_eff, width_ext, total;
  logic [LEN_W-1:0] prec_zeros_r, fixed_r, pad_r, len_r, n_r, cnt_load;

  assign dc_ext    = LEN_W'(dc_r);
  assign prec_ext  = LEN_W'(prec_r);
  assign prec_eff  = (dc_ext > prec_ext) ? dc_ext : prec_ext;
  assign width_ext = LEN_W'(width_r);
  assign total     = (width_ext > fixed_r) ? width_ext : fixed_r;

  always_comb begin
    case (cmd.phase)
      S_LEAD:  cnt_load = (!zero_r && !left_r) ? pad_r : '0;
      S_SIGN:  cnt_load = LEN_W'(sign_en_r);
      S_PFX:   cnt_load = LEN_W'(pfxlen_r);
      S_ZPAD:  cnt_load = zero_r ? pad_r : '0;
      S_PREC:  cnt_load = prec_zeros_r;
      S_DIG:   cnt_load = dc_ext;
      S_TRAIL: cnt_load = left_r ? pad_r : '0;
      default: cnt_load = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      prec_zeros_r <= prec_eff - dc_ext;
      fixed_r      <= prec_eff + LEN_W'(sign_en_r) + LEN_W'(pfxlen_r);
    end
    if (cmd.size) begin
      pad_r <= (width_ext > fixed_r) ? width_ext - fixed_r : '0;
      len_r <= (total > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : total;
      n_r   <= '0;
    end else if (cmd.emit) begin
      n_r <= n_r + LEN_W'(1);
    end
    if (cmd.ld_cnt) begin
      cnt_r <= cnt_load;
    end else if (cmd.emit) begin
      cnt_r <= cnt_m1;
    end
  end

  always_comb begin
    sts          = '0;
    sts.in_bad   = (in_data.base < 6'(RADIX_MIN)) || (in_data.base > 6'(RADIX_MAX));
    sts.dig_done = step_last;
    sts.q_zero   = (q_nxt == '0);
    sts.cnt_zero = (cnt_r == '0);
    sts.len_done = (n_r == len_r);
  end

  // character pipeline: stage 1 holds the phase and the digit read
  logic        e1_valid_r;
  ifmt_state_t e1_phase_r;
  logic        e1_x_r;
  logic        e1_last_r;
  logic        out_valid_r;
  ifmt_out_t   out_data_r;
  logic [7:0]  ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e1_valid_r  <= cmd.emit;
      out_valid_r <= e1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      e1_phase_r <= cmd.phase;
      e1_x_r     <= (cnt_r == LEN_W'(1)) && (pfxlen_r == 2'd2);
      e1_last_r  <= (cmd.phase == S_BAD) || (n_r == len_r - LEN_W'(1));
    end
  end

  always_comb begin
    case (e1_phase_r)
      S_SIGN:          ch = sign_ch_r;
      S_PFX:           ch = e1_x_r ? digit_char(6'(X_INDEX), lower_r) : CH_ZERO;
      S_ZPAD, S_PREC:  ch = CH_ZERO;
      S_DIG:           ch = digit_char(rd_data_r, lower_r);
      S_LEAD, S_TRAIL: ch = CH_SPACE;
      default:         ch = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e1_valid_r) begin
      out_data_r.out_char <= ch;
      out_data_r.is_last  <= e1_last_r;
      out_data_r.bad_base <= (e1_phase_r == S_BAD);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
